/* rtl/mdb_receive_checksum_ack_macros.svh */
// Assertion macros used by the receiver's checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef MDB_RECEIVE_CHECKSUM_ACK_MACROS_SVH
`define MDB_RECEIVE_CHECKSUM_ACK_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define MDBRX_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted
`define MDBRX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define MDBRX_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mdbrx_pkg.sv */
// Package for the MDB receiver: sizes, op and status codes, state type, result struct.
// No dependencies; used by every RTL file of the block but mdbrx_ram and the macro header.
package mdbrx_pkg;

  // Message buffer sizing
  localparam int BUF_DEPTH = 64;
  localparam int IDX_W     = $clog2(BUF_DEPTH + 1);
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(BUF_DEPTH);

  // Fixed field widths
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 7;

  // Reply bytes
  localparam logic [BYTE_W-1:0] ACK_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] NAK_BYTE = 8'hFF;

  // Status codes shown on rx_status
  localparam logic [STATUS_W-1:0] STAT_START  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_RECV   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_OK     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_CHKERR = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_OVER   = 3'd4;

  // Operation codes
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_READ    = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  // Receive state, one-hot
  typedef enum logic [4:0] {
    ST_START  = 5'b00001,
    ST_RECV   = 5'b00010,
    ST_OK     = 5'b00100,
    ST_CHKERR = 5'b01000,
    ST_OVER   = 5'b10000
  } rx_state_t;

  // Per-word result, everything but the buffered read byte
  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic [STATUS_W-1:0] rx_status;
    logic              read_valid;
    logic [FILL_W-1:0] fill_count;
  } res_t;

  // Map the one-hot state onto its status code
  function automatic logic [STATUS_W-1:0] status_code(rx_state_t s);
    logic [STATUS_W-1:0] code;
    unique case (s)
      ST_START:  code = STAT_START;
      ST_RECV:   code = STAT_RECV;
      ST_OK:     code = STAT_OK;
      ST_CHKERR: code = STAT_CHKERR;
      ST_OVER:   code = STAT_OVER;
      default:   code = STAT_START;
    endcase
    return code;
  endfunction

endpackage

/* rtl/mdbrx_ifs.sv */
// Handshake channels of the MDB receiver: input word, result word, mode write.
// Depends on mdbrx_pkg for field widths.

interface mdbrx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [mdbrx_pkg::BYTE_W-1:0] rx_byte;
  logic       mode_bit;
  logic       line_error;

  modport source (output valid, op, rx_byte, mode_bit, line_error, input ready);
  modport sink   (input valid, op, rx_byte, mode_bit, line_error, output ready);
endinterface

interface mdbrx_out_if;
  logic valid;
  logic ready;
  logic tx_valid;
  logic [mdbrx_pkg::BYTE_W-1:0]   tx_byte;
  logic [mdbrx_pkg::STATUS_W-1:0] rx_status;
  logic read_valid;
  logic [mdbrx_pkg::BYTE_W-1:0]   read_byte;
  logic [mdbrx_pkg::FILL_W-1:0]   fill_count;

  modport source (output valid, tx_valid, tx_byte, rx_status, read_valid, read_byte,
                  fill_count, input ready);
  modport sink   (input valid, tx_valid, tx_byte, rx_status, read_valid, read_byte,
                  fill_count, output ready);
endinterface

interface mdbrx_cfg_if;
  logic valid;
  logic ready;
  logic mdb_mode;

  modport source (output valid, mdb_mode, input ready);
  modport sink   (input valid, mdb_mode, output ready);
endinterface

/* rtl/mdbrx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mdbrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/mdbrx_step.sv */
// Receive state, checksum and buffer indices of the MDB receiver, plus the message buffer.
// Depends on mdbrx_pkg and mdbrx_ram.
module mdbrx_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [1:0]                    op,
  input  logic [mdbrx_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                          mode_bit,
  input  logic                          line_error,
  input  logic                          mdb_mode,
  output mdbrx_pkg::res_t               res,
  output logic [mdbrx_pkg::BYTE_W-1:0]  rd_data
);

  logic [mdbrx_pkg::IDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [mdbrx_pkg::IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [mdbrx_pkg::IDX_W-1:0]  fill_diff;
  mdbrx_pkg::rx_state_t         state_r, state_nxt;
  logic [mdbrx_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic                         room;
  logic                         store;
  logic                         fetch;
  logic                         tx_valid;
  logic [mdbrx_pkg::BYTE_W-1:0] tx_byte;

  assign room = (wr_idx_r < mdbrx_pkg::DEPTH_IDX);

  // Work out the effect of one word
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    store      = 1'b0;
    fetch      = 1'b0;
    tx_valid   = 1'b0;
    tx_byte    = mdbrx_pkg::ACK_BYTE;
    unique case (mdbrx_pkg::op_t'(op))
      mdbrx_pkg::OP_BYTE: begin
        if (mode_bit) begin
          // End of message: only while a message is open in MDB mode
          if (mdb_mode && (state_r == mdbrx_pkg::ST_START || state_r == mdbrx_pkg::ST_RECV)) begin
            tx_valid = 1'b1;
            if (!room) begin
              state_nxt = mdbrx_pkg::ST_OVER;
              tx_byte   = mdbrx_pkg::NAK_BYTE;
            end else if (state_r == mdbrx_pkg::ST_START) begin
              store     = 1'b1;
              state_nxt = mdbrx_pkg::ST_OK;
            end else begin
              store = 1'b1;
              if (rx_byte == sum_r) begin
                state_nxt = mdbrx_pkg::ST_OK;
              end else begin
                state_nxt = mdbrx_pkg::ST_CHKERR;
                tx_byte   = mdbrx_pkg::NAK_BYTE;
              end
            end
          end
        end else if (!line_error) begin
          // Data byte: buffer it if there is room and, in MDB mode, fold it into the checksum
          if (room) begin
            store = 1'b1;
            if (mdb_mode) begin
              state_nxt = mdbrx_pkg::ST_RECV;
              sum_nxt   = ((state_r == mdbrx_pkg::ST_START) ? '0 : sum_r) + rx_byte;
            end
          end else if (mdb_mode) begin
            state_nxt = mdbrx_pkg::ST_OVER;
            tx_valid  = 1'b1;
            tx_byte   = mdbrx_pkg::NAK_BYTE;
          end
        end
      end
      mdbrx_pkg::OP_CLEAR: begin
        wr_idx_nxt = '0;
        rd_idx_nxt = '0;
        state_nxt  = mdbrx_pkg::ST_START;
      end
      mdbrx_pkg::OP_READ: begin
        if (rd_idx_r < wr_idx_r) begin
          fetch      = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      mdbrx_pkg::OP_RELEASE: begin
        wr_idx_nxt = '0;
        rd_idx_nxt = '0;
      end
      default: begin
        wr_idx_nxt = wr_idx_r;
      end
    endcase
    if (store) begin
      wr_idx_nxt = wr_idx_r + 1'b1;
    end
  end

  // Result fields seen after this word
  assign fill_diff      = wr_idx_nxt - rd_idx_nxt;
  assign res.tx_valid   = tx_valid;
  assign res.tx_byte    = tx_valid ? tx_byte : '0;
  assign res.rx_status  = mdbrx_pkg::status_code(state_nxt);
  assign res.read_valid = fetch;
  assign res.fill_count = mdbrx_pkg::FILL_W'(fill_diff);

  // Advance the state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      state_r  <= mdbrx_pkg::ST_START;
      sum_r    <= '0;
    end else if (accept) begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      state_r  <= state_nxt;
      sum_r    <= sum_nxt;
    end
  end

  // Message buffer
  mdbrx_ram #(
    .WIDTH (mdbrx_pkg::BYTE_W),
    .DEPTH (mdbrx_pkg::BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (accept && store),
    .waddr (wr_idx_r[mdbrx_pkg::ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (accept && fetch),
    .raddr (rd_idx_r[mdbrx_pkg::ADDR_W-1:0]),
    .rdata (rd_data)
  );

endmodule

/* rtl/mdb_receive_checksum_ack.sv */
// MDB 9-bit receiver: buffering, checksum check and ACK/NAK reply, one result word per input word.
// Two stages: the state stage, then the result register, where a stalled result waits.
// Throughput: one word per cycle while out_if.ready is high.
// Reset clears the buffer indices, receive state and checksum, and sets mdb_mode to 1;
// buffer contents are left as they are and only written entries are ever read.
// Depends on mdbrx_pkg, mdbrx_ifs and mdbrx_step.
module mdb_receive_checksum_ack (
  input  logic        clk,
  input  logic        rst_n,
  mdbrx_in_if.sink    in_if,
  mdbrx_out_if.source out_if,
  mdbrx_cfg_if.sink   cfg_if
);

  logic                         mode_r;
  logic                         accept;
  logic                         out_adv;
  mdbrx_pkg::res_t              res;
  logic [mdbrx_pkg::BYTE_W-1:0] rd_data;
  logic                         s1_v_r, s1_v_nxt;
  mdbrx_pkg::res_t              s1_res_r;
  logic                         out_v_r, out_v_nxt;
  mdbrx_pkg::res_t              out_res_r;
  logic [mdbrx_pkg::BYTE_W-1:0] out_rd_r;

  // Mode register, always writable
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_if.valid) begin
      mode_r <= cfg_if.mdb_mode;
    end
  end

  // Handshake: take a word whenever the state stage can move on
  assign out_adv     = !out_v_r || out_if.ready;
  assign in_if.ready = !s1_v_r || out_adv;
  assign accept      = in_if.valid && in_if.ready;

  mdbrx_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_if.op),
    .rx_byte    (in_if.rx_byte),
    .mode_bit   (in_if.mode_bit),
    .line_error (in_if.line_error),
    .mdb_mode   (mode_r),
    .res        (res),
    .rd_data    (rd_data)
  );

  // Valid flags of both stages
  always_comb begin
    s1_v_nxt  = s1_v_r;
    out_v_nxt = out_v_r;
    if (out_adv) begin
      out_v_nxt = s1_v_r;
      s1_v_nxt  = 1'b0;
    end
    if (accept) begin
      s1_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Hold the word's result while the buffer read completes
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res;
    end
  end

  // Result register, joins in the buffered byte
  always_ff @(posedge clk) begin
    if (out_adv && s1_v_r) begin
      out_res_r <= s1_res_r;
      out_rd_r  <= s1_res_r.read_valid ? rd_data : '0;
    end
  end

  assign out_if.valid      = out_v_r;
  assign out_if.tx_valid   = out_res_r.tx_valid;
  assign out_if.tx_byte    = out_res_r.tx_byte;
  assign out_if.rx_status  = out_res_r.rx_status;
  assign out_if.read_valid = out_res_r.read_valid;
  assign out_if.read_byte  = out_rd_r;
  assign out_if.fill_count = out_res_r.fill_count;

endmodule

/* rtl/mdbrx_checker.sv */
// Port-level checks of the MDB receiver's result channel, bound to the top level.
// Depends on mdbrx_pkg and mdb_receive_checksum_ack_macros.svh.
`include "mdb_receive_checksum_ack_macros.svh"

module mdbrx_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            tx_valid,
  input logic [mdbrx_pkg::BYTE_W-1:0]    tx_byte,
  input logic [mdbrx_pkg::STATUS_W-1:0]  rx_status,
  input logic                            read_valid,
  input logic [mdbrx_pkg::BYTE_W-1:0]    read_byte
);

  // A stalled result word keeps its reply
  `MDBRX_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(tx_byte) && $stable(rx_status), "result changed while stalled")

  // Replies are ACK or NAK, and zero when nothing is sent
  `MDBRX_ASSERT_IMPL(a_reply, out_valid, (tx_valid && (tx_byte == mdbrx_pkg::ACK_BYTE || tx_byte == mdbrx_pkg::NAK_BYTE)) || (!tx_valid && tx_byte == mdbrx_pkg::ACK_BYTE), "bad reply byte")

  // No read data without a read
  `MDBRX_ASSERT_IMPL(a_rd_zero, out_valid && !read_valid, read_byte == '0, "read byte without read")

  // Status stays within its codes
  `MDBRX_ASSERT_IMPL(a_status, out_valid, rx_status <= mdbrx_pkg::STAT_OVER, "bad status code")

  // Nothing is offered right after reset
  `MDBRX_ASSERT_RST(a_reset, !rst_n, !out_valid, "result valid after reset")

endmodule

bind mdb_receive_checksum_ack mdbrx_checker u_mdbrx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .tx_valid   (out_if.tx_valid),
  .tx_byte    (out_if.tx_byte),
  .rx_status  (out_if.rx_status),
  .read_valid (out_if.read_valid),
  .read_byte  (out_if.read_byte)
);
